// File: src/cfpr_pkg.sv
// ----------------------------------------------------------------------------
// cfpr_pkg - shared types and constants for the framed packet receiver
// frame delimiters, command codes, verdict and class codes, result word
// layout and the byte-wise crc16 update
// ----------------------------------------------------------------------------
package cfpr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;

  localparam logic [BYTE_W-1:0] BYTE_START = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_END   = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_VALUES = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_IMU    = 8'h41;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd128;

  // result word kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_GOOD    = 2'd0;
  localparam logic [1:0] VERDICT_BAD_CRC = 2'd1;
  localparam logic [1:0] VERDICT_NO_END  = 2'd2;

  // frame class codes
  localparam logic [1:0] CLASS_VALUES = 2'd0;
  localparam logic [1:0] CLASS_IMU    = 2'd1;
  localparam logic [1:0] CLASS_OTHER  = 2'd2;

  typedef struct packed {
    logic              result_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [1:0]        verdict;
    logic [1:0]        frame_class;
    logic [BYTE_W-1:0] frame_length;
  } result_t;

  // crc16, msb first, one byte folded in with eight shift steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if ((crc & CRC_TOP) != '0) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// File: src/cfpr_rx_if.sv
// ----------------------------------------------------------------------------
// cfpr_rx_if - received byte channel
// valid/ready channel carrying one serial byte per word
// ----------------------------------------------------------------------------
interface cfpr_rx_if;
  logic                       valid;
  logic                       ready;
  logic [cfpr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: src/cfpr_res_if.sv
// ----------------------------------------------------------------------------
// cfpr_res_if - result channel
// valid/ready channel carrying payload bytes and end-of-frame verdicts
// ----------------------------------------------------------------------------
interface cfpr_res_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [cfpr_pkg::BYTE_W-1:0] data_byte;
  logic [cfpr_pkg::BYTE_W-1:0] byte_index;
  logic [1:0]                  verdict;
  logic [1:0]                  frame_class;
  logic [cfpr_pkg::BYTE_W-1:0] frame_length;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_index, output verdict, output frame_class,
                  output frame_length, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input byte_index, input verdict, input frame_class,
                  input frame_length, output ready);
endinterface

// File: src/crc_framed_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver_core - stx/length/crc16/etx frame receiver
// hunts for frames in a byte stream, passes payload bytes on and closes
// each frame with a good / bad crc / missing end verdict
// ----------------------------------------------------------------------------
// usage
//   rx_chan carries one received byte per word. result_chan carries either a
//   payload byte with its index (result_kind 0) or an end-of-frame verdict
//   with frame class and length (result_kind 1). a consumer drops the payload
//   of a frame whose verdict is not good.
//   cfg_wr_en / cfg_wr_data write max_payload_len; only while idle.
// throughput
//   one byte is taken every cycle while the skid stage is empty. a result
//   word goes into the output register, or into the skid stage while
//   result_chan stalls. the frame parser and the eight-step crc update sit
//   between the state registers and the output register, so one pass per byte.
// stalls
//   the output register is backed by a one-word skid stage: rx_chan.ready
//   stays high while the skid stage is empty, so a byte is still taken while
//   a result waits. ready drops only when both stages hold words.
// reset
//   rst (synchronous) returns to hunting for the start byte, empties both
//   output stages and sets max_payload_len to 128.
// ----------------------------------------------------------------------------
module crc_framed_packet_receiver_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [cfpr_pkg::BYTE_W-1:0] cfg_wr_data,
  cfpr_rx_if.sink                     rx_chan,
  cfpr_res_if.source                  result_chan
);

  // one-hot parser phases
  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_CRC_HI  = 6'b001000,
    PH_CRC_LO  = 6'b010000,
    PH_END     = 6'b100000
  } phase_t;

  // parser state
  phase_t                      phase, phase_next;
  logic [cfpr_pkg::BYTE_W-1:0] max_len;
  logic [cfpr_pkg::BYTE_W-1:0] payload_length, payload_length_next;
  logic [cfpr_pkg::BYTE_W-1:0] byte_count, byte_count_next;
  logic [cfpr_pkg::CRC_W-1:0]  running_crc, running_crc_next;
  logic [cfpr_pkg::CRC_W-1:0]  received_crc, received_crc_next;
  logic [cfpr_pkg::BYTE_W-1:0] command_byte, command_byte_next;

  // output register and skid stage
  logic              out_valid;
  cfpr_pkg::result_t out_word;
  logic              skid_valid;
  cfpr_pkg::result_t skid_word;

  logic                        fire;
  logic                        push;
  cfpr_pkg::result_t           new_word;
  logic [cfpr_pkg::BYTE_W-1:0] b;
  logic [cfpr_pkg::BYTE_W-1:0] count_inc;

  assign b         = rx_chan.rx_byte;
  assign fire      = rx_chan.valid && rx_chan.ready;
  assign count_inc = byte_count + 8'd1;

  // a new byte fits as long as the skid stage is free
  assign rx_chan.ready = !skid_valid;

  // frame parser, one byte per pass
  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    command_byte_next   = command_byte;
    push                = 1'b0;
    new_word            = '0;
    case (phase)
      PH_LEN: begin
        payload_length_next = b;
        byte_count_next     = '0;
        running_crc_next    = '0;
        // zero or oversize length: back to hunting
        phase_next = (b != '0 && b <= max_len) ? PH_PAYLOAD : PH_HUNT;
      end
      PH_PAYLOAD: begin
        if (byte_count == '0) begin
          command_byte_next = b;
        end
        running_crc_next     = cfpr_pkg::crc_byte(running_crc, b);
        push                 = 1'b1;
        new_word.result_kind = cfpr_pkg::KIND_PAYLOAD;
        new_word.data_byte   = b;
        new_word.byte_index  = byte_count;
        byte_count_next      = count_inc;
        if (count_inc == payload_length) begin
          phase_next = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        received_crc_next = {b, 8'h00};
        phase_next        = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        received_crc_next = {received_crc[15:8], b};
        phase_next        = PH_END;
      end
      PH_END: begin
        push                 = 1'b1;
        new_word.result_kind = cfpr_pkg::KIND_VERDICT;
        // a wrong end byte wins over a crc mismatch
        if (b != cfpr_pkg::BYTE_END) begin
          new_word.verdict = cfpr_pkg::VERDICT_NO_END;
        end else if (received_crc != running_crc) begin
          new_word.verdict = cfpr_pkg::VERDICT_BAD_CRC;
        end else begin
          new_word.verdict = cfpr_pkg::VERDICT_GOOD;
        end
        if (command_byte == cfpr_pkg::CMD_VALUES) begin
          new_word.frame_class = cfpr_pkg::CLASS_VALUES;
        end else if (command_byte == cfpr_pkg::CMD_IMU) begin
          new_word.frame_class = cfpr_pkg::CLASS_IMU;
        end else begin
          new_word.frame_class = cfpr_pkg::CLASS_OTHER;
        end
        new_word.frame_length = payload_length;
        // the byte after the end position is looked at afresh
        phase_next = PH_HUNT;
      end
      default: begin
        // hunting: only a start byte opens a frame
        phase_next = (b == cfpr_pkg::BYTE_START) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  // parser state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      max_len        <= cfpr_pkg::MAX_LEN_RESET;
      payload_length <= '0;
      byte_count     <= '0;
      running_crc    <= '0;
      received_crc   <= '0;
      command_byte   <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (fire) begin
        phase          <= phase_next;
        payload_length <= payload_length_next;
        byte_count     <= byte_count_next;
        running_crc    <= running_crc_next;
        received_crc   <= received_crc_next;
        command_byte   <= command_byte_next;
      end
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result_chan.ready) begin
      if (skid_valid) begin
        // skid drains first; no byte is taken this cycle
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fire && push;
      end
    end else if (fire && push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result_chan.ready) begin
      out_word <= skid_valid ? skid_word : new_word;
    end else if (fire && push) begin
      skid_word <= new_word;
    end
  end

  assign result_chan.valid        = out_valid;
  assign result_chan.result_kind  = out_word.result_kind;
  assign result_chan.data_byte    = out_word.data_byte;
  assign result_chan.byte_index   = out_word.byte_index;
  assign result_chan.verdict      = out_word.verdict;
  assign result_chan.frame_class  = out_word.frame_class;
  assign result_chan.frame_length = out_word.frame_length;

endmodule

// File: src/cfpr_checker.sv
// ----------------------------------------------------------------------------
// cfpr_checker - port-level checks for the frame receiver
// watches the byte and result channels of the top level
// ----------------------------------------------------------------------------
module cfpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_kind,
  input logic [7:0] res_data,
  input logic [7:0] res_index,
  input logic [1:0] res_verdict,
  input logic [1:0] res_class,
  input logic [7:0] res_length
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // an empty output side always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("byte channel stalled with empty output");

  // verdict words carry a real length and a defined verdict and class
  a_verdict_word: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_kind) |-> (res_length != 8'd0 && res_verdict != 2'd3 &&
                                 res_class != 2'd3 && res_index == 8'd0))
    else $error("malformed verdict word");

  // payload words leave the verdict fields clear
  a_payload_word: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_kind) |-> (res_verdict == 2'd0 && res_class == 2'd0 &&
                                  res_length == 8'd0))
    else $error("malformed payload word");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data) &&
                                   $stable(res_kind) && $stable(res_index)))
    else $error("stalled result changed");

endmodule

bind crc_framed_packet_receiver_core cfpr_checker u_cfpr_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_ready    (rx_chan.ready),
  .res_valid   (result_chan.valid),
  .res_ready   (result_chan.ready),
  .res_kind    (result_chan.result_kind),
  .res_data    (result_chan.data_byte),
  .res_index   (result_chan.byte_index),
  .res_verdict (result_chan.verdict),
  .res_class   (result_chan.frame_class),
  .res_length  (result_chan.frame_length)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for crc_framed_packet_receiver_core
// drives framed byte streams (good frames, bad crc, bad end byte, rejected
// lengths, stray and truncated bytes) under several max_payload_len values,
// predicts every payload and verdict word with a local frame parser and
// checks the result channel word by word with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  // parser phases of the local frame model
  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO, PH_END
  } rx_phase_e;

  // how a generated frame is damaged
  typedef enum int { FLAW_NONE, FLAW_CRC, FLAW_END } frame_flaw_e;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [cfpr_pkg::BYTE_W-1:0]   cfg_wr_data;

  cfpr_rx_if  rx_bus ();
  cfpr_res_if res_bus ();

  crc_framed_packet_receiver_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx_chan     (rx_bus),
    .result_chan (res_bus)
  );

  // frame model state, tracks the block word for word
  rx_phase_e                   model_phase;
  logic [7:0]                  model_len;
  logic [7:0]                  model_count;
  logic [cfpr_pkg::CRC_W-1:0]  model_crc;
  logic [cfpr_pkg::CRC_W-1:0]  model_rx_crc;
  logic [7:0]                  model_cmd;
  logic [7:0]                  model_max_len;

  // result words still owed by the block, oldest first
  cfpr_pkg::result_t pending_words[$];

  // stimulus side copy of the current length limit
  logic [7:0] limit_now;
  bit         idle_on;

  int mismatches;
  int bytes_sent;
  int frames_sent;
  int payload_checked;
  int good_seen, bad_crc_seen, no_end_seen;
  int cfg_writes;
  int cycles;

  // 10 unit clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, catches a hung handshake or a lost result
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles,
               pending_words.size());
      $display("crc_framed_packet_receiver_core: mismatch");
      $finish;
    end
  end

  // crc16 xmodem, one byte folded in bit by bit, msb first
  function automatic logic [cfpr_pkg::CRC_W-1:0] crc16_fold(
      input logic [cfpr_pkg::CRC_W-1:0] acc, input logic [7:0] din);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[cfpr_pkg::CRC_W-1] ^ din[i];
      acc = {acc[cfpr_pkg::CRC_W-2:0], 1'b0};
      if (fb) acc = acc ^ cfpr_pkg::CRC_POLY;
    end
    return acc;
  endfunction

  // advance the frame model by one accepted byte, queue any result word
  function automatic void step_deframer(input logic [7:0] b);
    cfpr_pkg::result_t w;
    w = '0;
    case (model_phase)
      PH_LEN: begin
        model_len   = b;
        model_count = '0;
        model_crc   = '0;
        // zero or over-limit length drops straight back to hunting
        model_phase = (b != 8'd0 && b <= model_max_len) ? PH_PAYLOAD : PH_HUNT;
      end
      PH_PAYLOAD: begin
        if (model_count == 8'd0) model_cmd = b;
        model_crc     = crc16_fold(model_crc, b);
        w.result_kind = cfpr_pkg::KIND_PAYLOAD;
        w.data_byte   = b;
        w.byte_index  = model_count;
        pending_words.push_back(w);
        model_count = model_count + 8'd1;
        if (model_count == model_len) model_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        model_rx_crc = {b, 8'h00};
        model_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        model_rx_crc[7:0] = b;
        model_phase       = PH_END;
      end
      PH_END: begin
        w.result_kind = cfpr_pkg::KIND_VERDICT;
        // a wrong end byte wins over a crc mismatch
        if (b != cfpr_pkg::BYTE_END)        w.verdict = cfpr_pkg::VERDICT_NO_END;
        else if (model_rx_crc != model_crc) w.verdict = cfpr_pkg::VERDICT_BAD_CRC;
        else                                w.verdict = cfpr_pkg::VERDICT_GOOD;
        if (model_cmd == cfpr_pkg::CMD_VALUES)   w.frame_class = cfpr_pkg::CLASS_VALUES;
        else if (model_cmd == cfpr_pkg::CMD_IMU) w.frame_class = cfpr_pkg::CLASS_IMU;
        else                                     w.frame_class = cfpr_pkg::CLASS_OTHER;
        w.frame_length = model_len;
        pending_words.push_back(w);
        // the end position byte is never taken as a new start byte
        model_phase = PH_HUNT;
      end
      default: begin
        model_phase = (b == cfpr_pkg::BYTE_START) ? PH_LEN : PH_HUNT;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // model update and result check, all sampled at the rising edge
  always @(posedge clk) begin
    cfpr_pkg::result_t seen;
    cfpr_pkg::result_t want;
    if (rst) begin
      model_phase   = PH_HUNT;
      model_len     = '0;
      model_count   = '0;
      model_crc     = '0;
      model_rx_crc  = '0;
      model_cmd     = '0;
      model_max_len = cfpr_pkg::MAX_LEN_RESET;
      pending_words.delete();
    end else begin
      if (cfg_wr_en) model_max_len = cfg_wr_data;
      if (rx_bus.valid && rx_bus.ready) step_deframer(rx_bus.rx_byte);
      if (res_bus.valid && res_bus.ready) begin
        seen.result_kind  = res_bus.result_kind;
        seen.data_byte    = res_bus.data_byte;
        seen.byte_index   = res_bus.byte_index;
        seen.verdict      = res_bus.verdict;
        seen.frame_class  = res_bus.frame_class;
        seen.frame_length = res_bus.frame_length;
        if (pending_words.size() == 0) begin
          report_mismatch("result word with none owed, kind", seen.result_kind, -1);
        end else begin
          want = pending_words.pop_front();
          if (seen.result_kind != want.result_kind)
            report_mismatch("result_kind", seen.result_kind, want.result_kind);
          if (seen.data_byte != want.data_byte)
            report_mismatch("data_byte", seen.data_byte, want.data_byte);
          if (seen.byte_index != want.byte_index)
            report_mismatch("byte_index", seen.byte_index, want.byte_index);
          if (seen.verdict != want.verdict)
            report_mismatch("verdict", seen.verdict, want.verdict);
          if (seen.frame_class != want.frame_class)
            report_mismatch("frame_class", seen.frame_class, want.frame_class);
          if (seen.frame_length != want.frame_length)
            report_mismatch("frame_length", seen.frame_length, want.frame_length);
          if (want.result_kind == cfpr_pkg::KIND_PAYLOAD) begin
            payload_checked++;
          end else begin
            case (want.verdict)
              cfpr_pkg::VERDICT_GOOD:    good_seen++;
              cfpr_pkg::VERDICT_BAD_CRC: bad_crc_seen++;
              default:                   no_end_seen++;
            endcase
          end
        end
      end
    end
  end

  // result side back-pressure: random bursts of stalls
  initial begin
    int hold;
    hold = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || !idle_on) begin
        hold = 0;
        res_bus.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        res_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 3) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // push one byte through rx_bus, returns at the edge that takes the word
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
    bytes_sent++;
  endtask

  // stx, length, payload, crc high/low, end byte
  task automatic send_frame(input int len, input logic [7:0] cmd,
                            input frame_flaw_e flaw);
    logic [cfpr_pkg::CRC_W-1:0] crc;
    logic [7:0]                 b;
    logic [7:0]                 tail;
    crc = '0;
    send_byte(cfpr_pkg::BYTE_START);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      b   = (i == 0) ? cmd : 8'($urandom_range(0, 255));
      crc = crc16_fold(crc, b);
      send_byte(b);
    end
    if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    tail = cfpr_pkg::BYTE_END;
    if (flaw == FLAW_END) begin
      do tail = 8'($urandom_range(0, 255)); while (tail == cfpr_pkg::BYTE_END);
    end
    send_byte(tail);
    frames_sent++;
  endtask

  // stop sending until every owed word is back, then let the pipe settle
  task automatic wait_drained();
    rx_bus.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // limit writes only happen with the block idle
  task automatic write_max_len(input logic [7:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = v;
    cfg_writes++;
  endtask

  // ---- tests ----------------------------------------------------------------

  // short directed stream: classes, verdicts, stray and embedded start bytes
  task automatic test_directed_frames();
    logic [cfpr_pkg::CRC_W-1:0] crc;
    crc = crc16_fold('0, cfpr_pkg::CMD_IMU);
    send_byte(8'hFF);                      // noise while hunting
    send_byte(8'h00);
    send_frame(1, cfpr_pkg::CMD_VALUES, FLAW_NONE);  // values class, good
    send_frame(1, cfpr_pkg::CMD_IMU, FLAW_CRC);      // imu class, crc mismatch
    send_byte(cfpr_pkg::BYTE_START);       // zero length, back to hunting
    send_byte(8'h00);
    send_frame(2, cfpr_pkg::BYTE_START, FLAW_NONE);  // start byte inside payload
    // frame whose end position holds a start byte
    send_byte(cfpr_pkg::BYTE_START);
    send_byte(8'd1);
    send_byte(cfpr_pkg::CMD_IMU);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    send_byte(cfpr_pkg::BYTE_START);       // wrong end byte that is a start byte
    send_byte(8'h05);                      // not a length, must be ignored
    frames_sent++;
    send_byte(cfpr_pkg::BYTE_START);       // over the reset limit
    send_byte(8'hFF);
  endtask

  // reset limit of 128: exactly at limit passes, one above is dropped
  task automatic test_limit_at_reset();
    send_frame(128, 8'($urandom_range(0, 255)), FLAW_NONE);
    send_byte(cfpr_pkg::BYTE_START);
    send_byte(8'd129);
    send_frame(3, cfpr_pkg::CMD_IMU, FLAW_END);
  endtask

  // smallest nonzero limit
  task automatic test_limit_one();
    write_max_len(8'd1);
    send_frame(1, cfpr_pkg::CMD_IMU, FLAW_NONE);
    send_byte(cfpr_pkg::BYTE_START);
    send_byte(8'd2);                       // rejected, above limit
    send_frame(1, 8'($urandom_range(0, 255)), FLAW_END);
  endtask

  // largest limit, frame long enough to reach byte index 254
  task automatic test_limit_full();
    write_max_len(8'd255);
    send_frame(255, 8'($urandom_range(0, 255)), FLAW_NONE);
    send_frame(3, cfpr_pkg::CMD_VALUES, FLAW_CRC);
  endtask

  // limit zero: every length is rejected, nothing may come out
  task automatic test_limit_zero();
    write_max_len(8'd0);
    send_byte(cfpr_pkg::BYTE_START);
    send_byte(8'd1);
    send_frame(1, cfpr_pkg::CMD_VALUES, FLAW_NONE);
    send_frame(2, cfpr_pkg::CMD_IMU, FLAW_NONE);
  endtask

  // mostly well formed frames with random content, plus damage and noise
  task automatic test_random_traffic(input int n_bytes, input bit with_idle);
    int          stop_at;
    int          pick;
    int          len;
    int          short_cap;
    logic [7:0]  cmd;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      // calm stretches between idling ones
      idle_on   = with_idle && ($urandom_range(0, 4) != 0);
      pick      = $urandom_range(0, 99);
      short_cap = (limit_now < 8) ? limit_now : 8;
      if (limit_now != 0)
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, limit_now)
                                           : $urandom_range(1, short_cap);
      case ($urandom_range(0, 3))
        0:       cmd = cfpr_pkg::CMD_VALUES;
        1:       cmd = cfpr_pkg::CMD_IMU;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      if (limit_now != 0 && pick < 70) begin
        send_frame(len, cmd, FLAW_NONE);
      end else if (limit_now != 0 && pick < 80) begin
        send_frame(len, cmd, FLAW_CRC);
      end else if (limit_now != 0 && pick < 88) begin
        send_frame(len, cmd, FLAW_END);
      end else if (pick < 93) begin
        // rejected length, followed by a few bytes the hunter skips
        send_byte(cfpr_pkg::BYTE_START);
        if (limit_now == 8'd255 || $urandom_range(0, 1) == 0) send_byte(8'd0);
        else send_byte(8'($urandom_range(limit_now + 1, 255)));
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(4, 255)));
      end else if (limit_now != 0 && pick < 96) begin
        // truncated frame, the next frame's bytes land in its payload
        send_byte(cfpr_pkg::BYTE_START);
        send_byte(8'(len));
        repeat ($urandom_range(0, len)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---- main sequence ---------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= '0;
    idle_on     = 1'b1;
    limit_now   = cfpr_pkg::MAX_LEN_RESET;
    mismatches  = 0;
    bytes_sent  = 0;
    frames_sent = 0;
    payload_checked = 0;
    good_seen   = 0;
    bad_crc_seen = 0;
    no_end_seen = 0;
    cfg_writes  = 0;
    cycles      = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_limit_at_reset();
    test_limit_one();
    test_limit_full();
    test_limit_zero();

    // random phases under different limits, each write drains the block first
    write_max_len(8'($urandom_range(1, 12)));
    test_random_traffic(30, 1'b1);
    write_max_len(8'd255);
    test_random_traffic(30, 1'b1);
    write_max_len(8'($urandom_range(13, 254)));
    test_random_traffic(30, 1'b1);
    write_max_len(8'($urandom_range(1, 4)));
    test_random_traffic(30, 1'b1);

    // last stretch runs with no idling on either side
    write_max_len(cfpr_pkg::MAX_LEN_RESET);
    idle_on = 1'b0;
    test_random_traffic(30, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch("words still owed at end", 0, pending_words.size());

    $display("covered %0d input words in %0d frames with %0d limit writes",
             bytes_sent, frames_sent, cfg_writes);
    $display("checked %0d payload words; verdicts good %0d, bad crc %0d, no end %0d",
             payload_checked, good_seen, bad_crc_seen, no_end_seen);
    if (mismatches == 0) begin
      $display("crc_framed_packet_receiver_core: match");
    end else begin
      $display("crc_framed_packet_receiver_core: mismatch");
    end
    $finish;
  end

endmodule
